// ----- design/mck_pkg.sv -----
// Shared types, constants and the character code table of the Morse code keyer.
`default_nettype none
package mck_pkg;

	localparam int DOT_W = 10;
	localparam int DUR_W = 13;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam logic [DOT_W-1:0] DOT_RESET = 10'd50;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [2:0] MAX_SYMBOLS = 3'd5;

	// Register index of the dot length register.
	localparam logic REG_DOT_LENGTH = 1'b0;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_message;
	} mck_item_t;

	typedef struct packed {
		logic             pin_level;
		logic [DUR_W-1:0] duration_ms;
		logic             last;
	} mck_result_t;

	// Classified character as handed from the front to the back.
	typedef struct packed {
		logic [2:0] sym_count;
		logic [4:0] symbols;
		logic       is_space;
		logic       eom;
	} mck_desc_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ON,
		BK_OFF,
		BK_SPACE,
		BK_EOM
	} mck_bk_state_t;

	typedef enum logic [1:0] {
		UNITS_1,
		UNITS_3,
		UNITS_7
	} mck_units_t;

	// Top 3 bits: symbol count; low 5 bits: symbols, first symbol in bit 0, 1 = dash.
	// Codes that are neither a digit nor a capital letter give zero.
	function automatic logic [7:0] code_lookup(input logic [7:0] ch);
		logic [7:0] code;
		code = 8'h00;
		case (ch)
			8'h30: code = 8'hBF;
			8'h31: code = 8'hBE;
			8'h32: code = 8'hBC;
			8'h33: code = 8'hB8;
			8'h34: code = 8'hB0;
			8'h35: code = 8'hA0;
			8'h36: code = 8'hA1;
			8'h37: code = 8'hA3;
			8'h38: code = 8'hA7;
			8'h39: code = 8'hAF;
			8'h41: code = 8'h42;
			8'h42: code = 8'h81;
			8'h43: code = 8'h85;
			8'h44: code = 8'h61;
			8'h45: code = 8'h20;
			8'h46: code = 8'h84;
			8'h47: code = 8'h63;
			8'h48: code = 8'h80;
			8'h49: code = 8'h40;
			8'h4A: code = 8'h8E;
			8'h4B: code = 8'h65;
			8'h4C: code = 8'h82;
			8'h4D: code = 8'h43;
			8'h4E: code = 8'h41;
			8'h4F: code = 8'h67;
			8'h50: code = 8'h86;
			8'h51: code = 8'h8B;
			8'h52: code = 8'h62;
			8'h53: code = 8'h60;
			8'h54: code = 8'h21;
			8'h55: code = 8'h64;
			8'h56: code = 8'h88;
			8'h57: code = 8'h66;
			8'h58: code = 8'h89;
			8'h59: code = 8'h8D;
			8'h5A: code = 8'h83;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

	// State in which the back starts playing a descriptor.
	function automatic mck_bk_state_t first_state(input mck_desc_t d);
		mck_bk_state_t s;
		priority if (d.sym_count != 3'd0) s = BK_ON;
		else if (d.is_space)             s = BK_SPACE;
		else                             s = BK_EOM;
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- design/morse_code_keyer.sv -----
// Top level of the Morse code keyer: configuration register, front, queue and back.
//
// Input channel: one ASCII character per beat (item.char_code) with an end of
// message flag. A beat is taken when push is high and full is low.
// Result channel: one pin segment per beat (level, duration in ms, last flag);
// the oldest segment is on result while empty is low and leaves when pop is high.
// Digits and capitals give one on segment per symbol (1 or 3 dots) each followed
// by a 1-dot off gap, the gap after the final symbol being 3 dots; a space gives
// a 3-dot off segment; the end of message flag adds a 7-dot off segment. Other
// characters give nothing and, without the end of message flag, are dropped by the front right away.
// When the back is idle, the first segment of a character passes through the queue,
// the back state register and the output register. The back sequencer emits at most
// one segment per cycle through a single output register; a character has up to 11
// segments, and it is loaded in a separate idle state when the back had gone idle.
// A short queue lets characters come in while the back is still playing.
// When the receiver stalls, the output register holds its segment and the back
// waits; once the queue fills, full rises and the input stalls in turn.
// Reset empties the queue and the output and sets the dot length to 50 ms.
// The dot length register (byte address 0) may only be written while idle.
`default_nettype none
module morse_code_keyer #(
	parameter int QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH
) (
	input  wire                  logic clk,
	input  wire                  logic arst_n,
	input  wire                  logic push,
	output logic                       full,
	input  wire                  mck_pkg::mck_item_t item,
	output logic                       empty,
	input  wire                  logic pop,
	output mck_pkg::mck_result_t       result,
	input  wire                  logic psel,
	input  wire                  logic penable,
	input  wire                  logic pwrite,
	input  wire                  logic [mck_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire                  logic [mck_pkg::CFG_DATA_W-1:0] pwdata,
	output logic                       [mck_pkg::CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	logic [mck_pkg::DOT_W-1:0] dot_length_q;
	logic                      reg_sel;
	mck_pkg::mck_desc_t        front_desc;
	mck_pkg::mck_desc_t        back_desc;
	logic                      q_push;
	logic                      q_full;
	logic                      q_pop;
	logic                      q_valid;

	// The register index is the address bit above the word offset.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[mck_pkg::CFG_ADDR_W-1] == mck_pkg::REG_DOT_LENGTH);
	assign prdata  = reg_sel ? {{(mck_pkg::CFG_DATA_W - mck_pkg::DOT_W){1'b0}}, dot_length_q}
	                         : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_length_q <= mck_pkg::DOT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			dot_length_q <= pwdata[mck_pkg::DOT_W-1:0];
		end
	end

	mck_front u_front (
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.q_push (q_push),
		.q_desc (front_desc)
	);

	mck_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (front_desc),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (back_desc),
		.valid   (q_valid)
	);

	mck_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dot_length (dot_length_q),
		.q_valid    (q_valid),
		.q_desc     (back_desc),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
`default_nettype wire

// ----- design/mck_front.sv -----
// Front of the keyer: accepts characters and classifies them into descriptors.
`default_nettype none
module mck_front (
	input  wire                logic      push,
	output logic                          full,
	input  wire                mck_pkg::mck_item_t item,
	input  wire                logic      q_full,
	output logic                          q_push,
	output mck_pkg::mck_desc_t            q_desc
);

	logic [7:0] code;
	logic [2:0] count;
	logic       accept;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign code   = mck_pkg::code_lookup(item.char_code);
	assign count  = (code[7:5] > mck_pkg::MAX_SYMBOLS) ? mck_pkg::MAX_SYMBOLS : code[7:5];

	always_comb begin
		q_desc.sym_count = count;
		q_desc.symbols   = code[4:0];
		q_desc.is_space  = (item.char_code == 8'h20);
		q_desc.eom       = item.end_of_message;
	end

	// Characters that give no segment at all never enter the queue.
	assign q_push = accept && ((count != 3'd0) || q_desc.is_space || q_desc.eom);

endmodule
`default_nettype wire

// ----- design/mck_queue.sv -----
// Short queue of classified characters between the front and the back.
`default_nettype none
module mck_queue #(
	parameter int DEPTH = mck_pkg::QUEUE_DEPTH
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic wr_en,
	input  wire                mck_pkg::mck_desc_t wr_data,
	output logic                     full,
	input  wire                logic rd_en,
	output mck_pkg::mck_desc_t       rd_data,
	output logic                     valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	mck_pkg::mck_desc_t  mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = (count_q == DEPTH_CNT);
	assign valid   = (count_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/mck_back.sv -----
// Back of the keyer: plays descriptors out as timed pin segments, one per cycle while the receiver keeps popping.
`default_nettype none
module mck_back (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic [mck_pkg::DOT_W-1:0] dot_length,
	input  wire                logic q_valid,
	input  wire                mck_pkg::mck_desc_t q_desc,
	output logic                     q_pop,
	output logic                     empty,
	input  wire                logic pop,
	output mck_pkg::mck_result_t     result
);

	mck_pkg::mck_bk_state_t state_q, state_d;
	logic [4:0]             sym_q;
	logic [2:0]             left_q;
	logic                   eom_q;
	mck_pkg::mck_result_t   out_q;
	logic                   out_valid_q;

	logic                   adv;
	logic                   seg_emit;
	logic                   seg_level;
	logic                   seg_last;
	mck_pkg::mck_units_t    seg_units;
	logic [mck_pkg::DUR_W-1:0] seg_dur;
	logic [mck_pkg::DUR_W-1:0] dot_ext;

	assign adv    = !out_valid_q || pop;
	assign empty  = !out_valid_q;
	assign result = out_q;

	// Segment that the current state emits.
	always_comb begin
		seg_emit  = 1'b1;
		seg_level = 1'b0;
		seg_last  = 1'b0;
		seg_units = mck_pkg::UNITS_1;
		unique case (state_q)
			mck_pkg::BK_IDLE: begin
				seg_emit = 1'b0;
			end
			mck_pkg::BK_ON: begin
				seg_level = 1'b1;
				seg_units = sym_q[0] ? mck_pkg::UNITS_3 : mck_pkg::UNITS_1;
			end
			mck_pkg::BK_OFF: begin
				seg_units = (left_q == 3'd1) ? mck_pkg::UNITS_3 : mck_pkg::UNITS_1;
				seg_last  = (left_q == 3'd1) && !eom_q;
			end
			mck_pkg::BK_SPACE: begin
				seg_units = mck_pkg::UNITS_3;
				seg_last  = !eom_q;
			end
			mck_pkg::BK_EOM: begin
				seg_units = mck_pkg::UNITS_7;
				seg_last  = 1'b1;
			end
			default: begin
				seg_emit = 1'b0;
			end
		endcase
	end

	assign dot_ext = {{(mck_pkg::DUR_W - mck_pkg::DOT_W){1'b0}}, dot_length};

	always_comb begin
		unique case (seg_units)
			mck_pkg::UNITS_1: seg_dur = dot_ext;
			mck_pkg::UNITS_3: seg_dur = (dot_ext << 1) + dot_ext;
			mck_pkg::UNITS_7: seg_dur = (dot_ext << 3) - dot_ext;
			default:          seg_dur = dot_ext;
		endcase
	end

	// Next state and queue pop.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		if (state_q == mck_pkg::BK_IDLE) begin
			q_pop   = q_valid;
			state_d = q_valid ? mck_pkg::first_state(q_desc) : mck_pkg::BK_IDLE;
		end else if (adv) begin
			if (seg_last) begin
				q_pop   = q_valid;
				state_d = q_valid ? mck_pkg::first_state(q_desc) : mck_pkg::BK_IDLE;
			end else begin
				unique case (state_q)
					mck_pkg::BK_ON:    state_d = mck_pkg::BK_OFF;
					mck_pkg::BK_OFF:   state_d = (left_q == 3'd1) ? mck_pkg::BK_EOM
					                                               : mck_pkg::BK_ON;
					mck_pkg::BK_SPACE: state_d = mck_pkg::BK_EOM;
					default:           state_d = mck_pkg::BK_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mck_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_valid_q <= seg_emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			sym_q  <= q_desc.symbols;
			left_q <= q_desc.sym_count;
			eom_q  <= q_desc.eom;
		end else if (adv && (state_q == mck_pkg::BK_OFF)) begin
			sym_q  <= sym_q >> 1;
			left_q <= left_q - 3'd1;
		end
		if (adv && seg_emit) begin
			out_q.pin_level   <= seg_level;
			out_q.duration_ms <= seg_dur;
			out_q.last        <= seg_last;
		end
	end

endmodule
`default_nettype wire
